@@ design/pfcf_pkg.sv @@
// pfcf_pkg: shared types and constants of the pressure/flow calibration filter
// used by pfcf_serial and pressure_flow_calibrate_filter
`default_nettype none

package pfcf_pkg;

   // datapath widths that do not vary
   localparam int ACC_W       = 64;
   localparam int DIV_W       = 37;
   localparam int P_STATE_W   = 32;
   localparam int F_STATE_W   = 40;
   localparam int P_OUT_W     = 12;
   localparam int F_OUT_W     = 15;

   // conversion constants, flow coefficients are scaled by 1e11
   localparam logic [16:0]      PRESS_GAIN = 17'd95321;
   localparam logic [DIV_W-1:0] PRESS_DIV  = 37'd1000000;
   localparam logic [DIV_W-1:0] FLOW_DIV   = 37'd100000000000;
   localparam logic [DIV_W-1:0] P_ALPHA_K  = 37'd20;
   localparam logic [DIV_W-1:0] F_ALPHA_K  = 37'd10;

   // register indexes
   localparam logic CSR_PRESSURE_BASE = 1'b0;
   localparam logic CSR_FLOW_BASE     = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_P_MUL,
      ST_P_DIV,
      ST_F_MUL,
      ST_F_DIV,
      ST_P_FILT,
      ST_F_FILT,
      ST_LOAD
   } state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } ser_op_type;

   typedef enum logic [1:0] {
      SEG_LOW,
      SEG_MID,
      SEG_HIGH
   } seg_type;

   typedef struct packed {
      logic       start;
      ser_op_type op;
   } ser_cmd_type;

   // horner coefficients, idx 0 is the highest power
   function automatic logic signed [ACC_W-1:0] coef(seg_type seg, logic [1:0] idx);
      logic signed [ACC_W-1:0] c;
      c = '0;
      unique case (seg)
         SEG_LOW: begin
            unique case (idx)
               2'd0: c = 64'sd254190;
               2'd1: c = -64'sd175670000;
               2'd2: c = 64'sd45320000000;
               2'd3: c = -64'sd251340000000;
            endcase
         end
         SEG_MID: begin
            unique case (idx)
               2'd0: c = 64'sd41106;
               2'd1: c = -64'sd50160000;
               2'd2: c = 64'sd24597000000;
               2'd3: c = -64'sd576920000000;
            endcase
         end
         SEG_HIGH: begin
            unique case (idx)
               2'd0: c = 64'sd0;
               2'd1: c = -64'sd908250;
               2'd2: c = 64'sd6371700000;
               2'd3: c = -64'sd2575700000000;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

@@ design/pressure_flow_calibrate_filter.sv @@
// pressure_flow_calibrate_filter: pressure/flow calibration with two low-pass filters
// depends on pfcf_pkg and pfcf_serial
//
// Usage:
//   req channel (valid/ready) carries one raw pressure and one raw flow sample.
//   rsp channel (valid/ready) returns the filtered pressure and flow values.
//   csr port writes the two zero baselines (index 0 pressure, 1 flow); write
//   only while no transfer is in flight.
//   One item at a time: req_ready is high only while the sequencer is idle.
//   Each item passes in turn through the single bit-serial unit: four
//   multiplies and four divides, each with a handover, then a load state.
//   The result sits in an output register, so a new item is accepted while
//   a stalled result waits; a finished item waits in its last step only when
//   that register is still full.
//   Reset sets both baselines to mid scale and clears both filter states.
`default_nettype none

module pressure_flow_calibrate_filter #(
   parameter int SAMPLE_BITS = 14,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [SAMPLE_BITS-1:0]                req_pressure_sample,
   input  wire logic [SAMPLE_BITS-1:0]                req_flow_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [pfcf_pkg::P_OUT_W-1:0]        rsp_pressure_out,
   output logic signed [pfcf_pkg::F_OUT_W-1:0]        rsp_flow_out,
   input  wire logic                                  csr_write,
   input  wire logic                                  csr_index,
   input  wire logic [SAMPLE_BITS-1:0]                csr_data
);

   localparam int AW   = pfcf_pkg::ACC_W;
   localparam int DW   = pfcf_pkg::DIV_W;
   localparam int PSW  = pfcf_pkg::P_STATE_W;
   localparam int FSW  = pfcf_pkg::F_STATE_W;
   localparam int POW  = pfcf_pkg::P_OUT_W;
   localparam int FOW  = pfcf_pkg::F_OUT_W;
   localparam int MB   = (SAMPLE_BITS > 17) ? SAMPLE_BITS : 17;
   localparam int SDW  = SAMPLE_BITS + 1;
   localparam int CP_W = SAMPLE_BITS;
   localparam int CF_W = 2 * SAMPLE_BITS - 4;

   localparam logic [SAMPLE_BITS-1:0] BASE_RST = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic signed [AW-1:0] P_ST_MAX = (64'sd1 <<< (PSW - 1)) - 64'sd1;
   localparam logic signed [AW-1:0] P_ST_MIN = -P_ST_MAX - 64'sd1;
   localparam logic signed [AW-1:0] F_ST_MAX = (64'sd1 <<< (FSW - 1)) - 64'sd1;
   localparam logic signed [AW-1:0] F_ST_MIN = -F_ST_MAX - 64'sd1;
   localparam logic signed [PSW:0] P_OUT_MAX = (PSW+1)'((1 <<< (POW - 1)) - 1);
   localparam logic signed [PSW:0] P_OUT_MIN = -P_OUT_MAX - (PSW+1)'(1);
   localparam logic signed [FSW:0] F_OUT_MAX = (FSW+1)'((1 <<< (FOW - 1)) - 1);
   localparam logic signed [FSW:0] F_OUT_MIN = -F_OUT_MAX - (FSW+1)'(1);

   function automatic logic [AW-1:0] mag64(logic signed [AW-1:0] v);
      return v[AW-1] ? AW'(-v) : AW'(v);
   endfunction

   pfcf_pkg::state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0]          pbase_ff, pbase_in;
   logic [SAMPLE_BITS-1:0]          fbase_ff, fbase_in;
   logic [SAMPLE_BITS-1:0]          p_mag_ff, p_mag_in;
   logic                            p_neg_ff, p_neg_in;
   logic [SAMPLE_BITS-1:0]          m_ff, m_in;
   logic                            f_neg_ff, f_neg_in;
   pfcf_pkg::seg_type               seg_ff, seg_in;
   logic signed [AW-1:0]            v_ff, v_in;
   logic [1:0]                      term_ff, term_in;
   logic signed [CP_W-1:0]          cp_ff, cp_in;
   logic signed [CF_W-1:0]          cf_ff, cf_in;
   logic signed [PSW-1:0]           sp_ff, sp_in;
   logic signed [FSW-1:0]           sf_ff, sf_in;
   logic                            issued_ff, issued_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [POW-1:0]           rsp_p_ff, rsp_p_in;
   logic signed [FOW-1:0]           rsp_f_ff, rsp_f_in;

   pfcf_pkg::ser_cmd_type           ser_cmd;
   logic [AW-1:0]                   ser_a;
   logic [MB-1:0]                   ser_b;
   logic [DW-1:0]                   ser_d;
   logic [AW-1:0]                   ser_result;
   logic                            ser_done;

   logic                            accept, load_ok, computing;
   logic signed [SDW-1:0]           dp, df;
   logic signed [AW-1:0]            v11, pn, fn, q_s, q_neg, sp64, sf64;
   logic signed [PSW:0]             p_ext, p_abs, p_val;
   logic signed [FSW:0]             f_ext, f_abs, f_val;

   pfcf_serial #(
      .MB(MB)
   ) u_serial (
      .clock (clock),
      .reset (reset),
      .cmd   (ser_cmd),
      .a_in  (ser_a),
      .b_in  (ser_b),
      .d_in  (ser_d),
      .result(ser_result),
      .done  (ser_done)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfcf_pkg::ST_IDLE:   if (req_valid) state_in = pfcf_pkg::ST_P_MUL;
         pfcf_pkg::ST_P_MUL:  if (ser_done) state_in = pfcf_pkg::ST_P_DIV;
         pfcf_pkg::ST_P_DIV:  if (ser_done) state_in = pfcf_pkg::ST_F_MUL;
         pfcf_pkg::ST_F_MUL:  if (ser_done && term_ff == 2'd2) state_in = pfcf_pkg::ST_F_DIV;
         pfcf_pkg::ST_F_DIV:  if (ser_done) state_in = pfcf_pkg::ST_P_FILT;
         pfcf_pkg::ST_P_FILT: if (ser_done) state_in = pfcf_pkg::ST_F_FILT;
         pfcf_pkg::ST_F_FILT: if (ser_done) state_in = pfcf_pkg::ST_LOAD;
         pfcf_pkg::ST_LOAD:   if (load_ok) state_in = pfcf_pkg::ST_IDLE;
      endcase
   end

   // filter numerators and scaled flow value
   always_comb begin
      sp64 = AW'(sp_ff);
      sf64 = AW'(sf_ff);
      v11  = (v_ff <<< 3) + (v_ff <<< 1) + v_ff;
      pn   = (AW'(cp_ff) <<< FRAC_BITS) + (sp64 <<< 4) + (sp64 <<< 1) + sp64;
      fn   = (AW'(cf_ff) <<< FRAC_BITS) + (sf64 <<< 3) + sf64;
   end

   // sequencer outputs and serial unit operands
   always_comb begin
      req_ready  = 1'b0;
      computing  = 1'b0;
      ser_cmd.op = pfcf_pkg::OP_DIV;
      ser_a      = '0;
      ser_b      = '0;
      ser_d      = pfcf_pkg::PRESS_DIV;
      unique case (state_ff)
         pfcf_pkg::ST_IDLE: req_ready = 1'b1;
         pfcf_pkg::ST_P_MUL: begin
            computing  = 1'b1;
            ser_cmd.op = pfcf_pkg::OP_MUL;
            ser_a      = AW'(p_mag_ff);
            ser_b      = MB'(pfcf_pkg::PRESS_GAIN);
         end
         pfcf_pkg::ST_P_DIV: begin
            computing = 1'b1;
            ser_a     = ser_result;
            ser_d     = pfcf_pkg::PRESS_DIV;
         end
         pfcf_pkg::ST_F_MUL: begin
            computing  = 1'b1;
            ser_cmd.op = pfcf_pkg::OP_MUL;
            ser_a      = mag64(v_ff);
            ser_b      = MB'(m_ff);
         end
         pfcf_pkg::ST_F_DIV: begin
            computing = 1'b1;
            ser_a     = mag64(v11);
            ser_d     = pfcf_pkg::FLOW_DIV;
         end
         pfcf_pkg::ST_P_FILT: begin
            computing = 1'b1;
            ser_a     = mag64(pn);
            ser_d     = pfcf_pkg::P_ALPHA_K;
         end
         pfcf_pkg::ST_F_FILT: begin
            computing = 1'b1;
            ser_a     = mag64(fn);
            ser_d     = pfcf_pkg::F_ALPHA_K;
         end
         pfcf_pkg::ST_LOAD: req_ready = 1'b0;
      endcase
      ser_cmd.start = computing && !issued_ff;
   end

   assign accept  = req_valid && req_ready;
   assign load_ok = !rsp_valid_ff || rsp_ready;
   assign q_s     = $signed(ser_result);
   assign q_neg   = -q_s;

   // datapath next values
   always_comb begin
      pbase_in  = pbase_ff;
      fbase_in  = fbase_ff;
      p_mag_in  = p_mag_ff;
      p_neg_in  = p_neg_ff;
      m_in      = m_ff;
      f_neg_in  = f_neg_ff;
      seg_in    = seg_ff;
      v_in      = v_ff;
      term_in   = term_ff;
      cp_in     = cp_ff;
      cf_in     = cf_ff;
      sp_in     = sp_ff;
      sf_in     = sf_ff;
      issued_in = issued_ff;
      dp        = $signed({1'b0, req_pressure_sample}) - $signed({1'b0, pbase_ff});
      df        = $signed({1'b0, req_flow_sample}) - $signed({1'b0, fbase_ff});

      // baseline writes
      if (csr_write) begin
         unique case (csr_index)
            pfcf_pkg::CSR_PRESSURE_BASE: pbase_in = csr_data;
            pfcf_pkg::CSR_FLOW_BASE:     fbase_in = csr_data;
         endcase
      end

      // serial unit handshake
      if (ser_done) begin
         issued_in = 1'b0;
      end else if (ser_cmd.start) begin
         issued_in = 1'b1;
      end

      // capture calibrated differences on transfer
      if (accept) begin
         p_neg_in = dp[SDW-1];
         p_mag_in = dp[SDW-1] ? SAMPLE_BITS'(-dp) : SAMPLE_BITS'(dp);
         f_neg_in = df[SDW-1];
         m_in     = df[SDW-1] ? SAMPLE_BITS'(-df) : SAMPLE_BITS'(df);
         if (m_in <= SAMPLE_BITS'(20)) begin
            seg_in = pfcf_pkg::SEG_LOW;
         end else if (m_in <= SAMPLE_BITS'(450)) begin
            seg_in = pfcf_pkg::SEG_MID;
         end else begin
            seg_in = pfcf_pkg::SEG_HIGH;
         end
      end

      // results of each serial operation
      if (ser_done) begin
         unique case (state_ff)
            pfcf_pkg::ST_P_DIV: begin
               cp_in   = p_neg_ff ? CP_W'(q_neg) : CP_W'(q_s);
               v_in    = pfcf_pkg::coef(seg_ff, 2'd0);
               term_in = 2'd0;
            end
            pfcf_pkg::ST_F_MUL: begin
               v_in    = (v_ff[AW-1] ? q_neg : q_s)
                         + pfcf_pkg::coef(seg_ff, term_ff + 2'd1);
               term_in = term_ff + 2'd1;
            end
            pfcf_pkg::ST_F_DIV: begin
               cf_in = (v_ff[AW-1] ^ f_neg_ff) ? CF_W'(q_neg) : CF_W'(q_s);
            end
            pfcf_pkg::ST_P_FILT: begin
               priority if ((pn[AW-1] ? q_neg : q_s) > P_ST_MAX) begin
                  sp_in = PSW'(P_ST_MAX);
               end else if ((pn[AW-1] ? q_neg : q_s) < P_ST_MIN) begin
                  sp_in = PSW'(P_ST_MIN);
               end else begin
                  sp_in = pn[AW-1] ? PSW'(q_neg) : PSW'(q_s);
               end
            end
            pfcf_pkg::ST_F_FILT: begin
               priority if ((fn[AW-1] ? q_neg : q_s) > F_ST_MAX) begin
                  sf_in = FSW'(F_ST_MAX);
               end else if ((fn[AW-1] ? q_neg : q_s) < F_ST_MIN) begin
                  sf_in = FSW'(F_ST_MIN);
               end else begin
                  sf_in = fn[AW-1] ? FSW'(q_neg) : FSW'(q_s);
               end
            end
            default: v_in = v_ff;
         endcase
      end
   end

   // integer part of the filter states, truncated toward zero and clamped
   always_comb begin
      p_ext = (PSW+1)'(sp_ff);
      p_abs = sp_ff[PSW-1] ? -p_ext : p_ext;
      p_val = sp_ff[PSW-1] ? -(p_abs >>> FRAC_BITS) : (p_abs >>> FRAC_BITS);
      f_ext = (FSW+1)'(sf_ff);
      f_abs = sf_ff[FSW-1] ? -f_ext : f_ext;
      f_val = sf_ff[FSW-1] ? -(f_abs >>> FRAC_BITS) : (f_abs >>> FRAC_BITS);

      rsp_valid_in = rsp_valid_ff;
      rsp_p_in     = rsp_p_ff;
      rsp_f_in     = rsp_f_ff;
      if (state_ff == pfcf_pkg::ST_LOAD && load_ok) begin
         rsp_valid_in = 1'b1;
         priority if (p_val > P_OUT_MAX) begin
            rsp_p_in = POW'(P_OUT_MAX);
         end else if (p_val < P_OUT_MIN) begin
            rsp_p_in = POW'(P_OUT_MIN);
         end else begin
            rsp_p_in = POW'(p_val);
         end
         priority if (f_val > F_OUT_MAX) begin
            rsp_f_in = FOW'(F_OUT_MAX);
         end else if (f_val < F_OUT_MIN) begin
            rsp_f_in = FOW'(F_OUT_MIN);
         end else begin
            rsp_f_in = FOW'(f_val);
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfcf_pkg::ST_IDLE;
         pbase_ff     <= BASE_RST;
         fbase_ff     <= BASE_RST;
         sp_ff        <= '0;
         sf_ff        <= '0;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pbase_ff     <= pbase_in;
         fbase_ff     <= fbase_in;
         sp_ff        <= sp_in;
         sf_ff        <= sf_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_mag_ff <= p_mag_in;
      p_neg_ff <= p_neg_in;
      m_ff     <= m_in;
      f_neg_ff <= f_neg_in;
      seg_ff   <= seg_in;
      v_ff     <= v_in;
      term_ff  <= term_in;
      cp_ff    <= cp_in;
      cf_ff    <= cf_in;
      rsp_p_ff <= rsp_p_in;
      rsp_f_ff <= rsp_f_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressure_out = rsp_p_ff;
   assign rsp_flow_out     = rsp_f_ff;

endmodule

`default_nettype wire

@@ design/pfcf_serial.sv @@
// pfcf_serial: bit-serial unit, shift-add multiply or restoring divide by a constant
// depends on pfcf_pkg
`default_nettype none

module pfcf_serial #(
   parameter int MB = 17
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire pfcf_pkg::ser_cmd_type       cmd,
   input  wire logic [pfcf_pkg::ACC_W-1:0]  a_in,
   input  wire logic [MB-1:0]               b_in,
   input  wire logic [pfcf_pkg::DIV_W-1:0]  d_in,
   output logic      [pfcf_pkg::ACC_W-1:0]  result,
   output logic                             done
);

   localparam int AW    = pfcf_pkg::ACC_W;
   localparam int DW    = pfcf_pkg::DIV_W;
   localparam int CNT_W = $clog2(AW + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   pfcf_pkg::ser_op_type   op_ff, op_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]          x_ff, x_in;
   logic [MB-1:0]          y_ff, y_in;
   logic [AW-1:0]          r_ff, r_in;
   logic [DW-1:0]          d_ff, d_in_ff;

   logic [AW-1:0]          x_step, r_step;
   logic [MB-1:0]          y_step;
   logic [DW:0]            sh, diff;
   logic                   ge;

   // one bit of work per cycle while busy
   always_comb begin
      sh     = {r_ff[DW-1:0], x_ff[AW-1]};
      diff   = sh - {1'b0, d_ff};
      ge     = (sh >= {1'b0, d_ff});
      x_step = x_ff;
      y_step = y_ff;
      r_step = r_ff;
      unique case (op_ff)
         pfcf_pkg::OP_MUL: begin
            r_step = y_ff[0] ? (r_ff + x_ff) : r_ff;
            x_step = {x_ff[AW-2:0], 1'b0};
            y_step = {1'b0, y_ff[MB-1:1]};
         end
         pfcf_pkg::OP_DIV: begin
            r_step = ge ? AW'(diff[DW-1:0]) : AW'(sh[DW-1:0]);
            x_step = {x_ff[AW-2:0], ge};
         end
      endcase
   end

   // load on start, iterate while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      d_in_ff = d_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = (cmd.op == pfcf_pkg::OP_MUL) ? CNT_W'(MB) : CNT_W'(AW);
         x_in    = a_in;
         y_in    = b_in;
         r_in    = '0;
         d_in_ff = d_in;
      end else if (busy_ff) begin
         x_in   = x_step;
         y_in   = y_step;
         r_in   = r_step;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      d_ff   <= d_in_ff;
   end

   assign result = (op_ff == pfcf_pkg::OP_MUL) ? r_ff : x_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

@@ bench/pressure_flow_calibrate_filter_test.sv @@
// pressure_flow_calibrate_filter_test: self-checking bench for the calibration filter
// predicts both filtered outputs per transfer and checks them in order
// depends on pfcf_pkg and the pressure_flow_calibrate_filter design
`default_nettype none

module pressure_flow_calibrate_filter_test;

   localparam int SB         = 14;
   localparam int FB         = 16;
   localparam int SMAX       = (1 << SB) - 1;
   localparam int IDLE_LIMIT = 30000;

   typedef struct packed {
      logic signed [pfcf_pkg::P_OUT_W-1:0] pressure;
      logic signed [pfcf_pkg::F_OUT_W-1:0] flow;
   } filt_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SB-1:0] req_pressure_sample = '0;
   logic [SB-1:0] req_flow_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [pfcf_pkg::P_OUT_W-1:0] rsp_pressure_out;
   logic signed [pfcf_pkg::F_OUT_W-1:0] rsp_flow_out;
   logic csr_write = 1'b0;
   logic csr_index = 1'b0;
   logic [SB-1:0] csr_data = '0;

   // predictor copy of state and baselines
   longint press_base;
   longint flow_zero;
   longint press_state;
   longint flow_state;
   filt_out_type filt_due[$];

   int errors = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int hold_off = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   pressure_flow_calibrate_filter #(.SAMPLE_BITS(SB), .FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pressure_sample(req_pressure_sample), .req_flow_sample(req_flow_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_pressure_out(rsp_pressure_out), .rsp_flow_out(rsp_flow_out),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint clamp_signed(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // calibrated flow, polynomial picked by magnitude, scale 1e11
   function automatic longint flow_convert(longint d);
      longint m;
      longint num;
      m = (d < 0) ? -d : d;
      if (m <= 20)
         num = 64'sd254190 * m * m * m - 64'sd175670000 * m * m
               + 64'sd45320000000 * m - 64'sd251340000000;
      else if (m <= 450)
         num = 64'sd41106 * m * m * m - 64'sd50160000 * m * m
               + 64'sd24597000000 * m - 64'sd576920000000;
      else
         num = -64'sd908250 * m * m + 64'sd6371700000 * m - 64'sd2575700000000;
      num = num * 11;
      if (d < 0) num = -num;
      return num / 64'sd100000000000;
   endfunction

   // one filter step for both channels, returns the integer outputs
   function automatic filt_out_type filter_step(logic [SB-1:0] ps, logic [SB-1:0] fs);
      longint dp;
      longint df;
      longint px;
      longint fx;
      filt_out_type r;
      dp = longint'(ps) - press_base;
      df = longint'(fs) - flow_zero;
      px = (dp * 95321) / 1000000;
      fx = flow_convert(df);
      press_state = clamp_signed((px * (longint'(1) <<< FB) + 19 * press_state) / 20,
                                 pfcf_pkg::P_STATE_W);
      flow_state = clamp_signed((fx * (longint'(1) <<< FB) + 9 * flow_state) / 10,
                                pfcf_pkg::F_STATE_W);
      r.pressure = pfcf_pkg::P_OUT_W'(clamp_signed(press_state / (longint'(1) <<< FB),
                                                   pfcf_pkg::P_OUT_W));
      r.flow = pfcf_pkg::F_OUT_W'(clamp_signed(flow_state / (longint'(1) <<< FB),
                                               pfcf_pkg::F_OUT_W));
      return r;
   endfunction

   // one request transfer, with burst and gap pacing
   task automatic send_sample(int ps, int fs);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pressure_sample <= SB'(ps);
      req_flow_sample <= SB'(fs);
      do @(posedge clock); while (!req_ready);
      filt_due.push_back(filter_step(SB'(ps), SB'(fs)));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (filt_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_base(logic idx, int value);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= SB'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == pfcf_pkg::CSR_PRESSURE_BASE) press_base = value;
      else flow_zero = value;
      @(posedge clock);
   endtask

   // sample near a baseline so all three flow segments get hit
   function automatic int near_base(longint b);
      int d;
      int v;
      case ($urandom_range(0, 2))
         0: d = $urandom_range(0, 20);
         1: d = $urandom_range(21, 450);
         default: d = $urandom_range(451, SMAX);
      endcase
      v = ($urandom_range(0, 1) != 0) ? int'(b) + d : int'(b) - d;
      if (v < 0) v = 0;
      if (v > SMAX) v = SMAX;
      return v;
   endfunction

   task automatic test_directed;
      int m [8];
      m = '{0, 1, 20, 21, 450, 451, 2000, 8191};
      send_sample(0, 0);
      send_sample(SMAX, SMAX);
      foreach (m[i]) begin
         send_sample(8192 + m[i], 8192 + m[i]);
         send_sample(8192 - m[i], 8192 - m[i]);
      end
      // baseline extremes with full scale swing
      write_base(pfcf_pkg::CSR_PRESSURE_BASE, 0);
      write_base(pfcf_pkg::CSR_FLOW_BASE, SMAX);
      send_sample(SMAX, 0);
      send_sample(SMAX, SMAX);
      write_base(pfcf_pkg::CSR_PRESSURE_BASE, SMAX);
      write_base(pfcf_pkg::CSR_FLOW_BASE, 0);
      send_sample(0, SMAX);
      send_sample(SMAX, 0);
   endtask

   task automatic test_random(int count);
      int ps;
      int fs;
      for (int i = 0; i < count; i++) begin
         if (i % 200 == 0) begin
            case ((i / 200) % 4)
               0: write_base(pfcf_pkg::CSR_PRESSURE_BASE, $urandom_range(0, SMAX));
               1: write_base(pfcf_pkg::CSR_FLOW_BASE, $urandom_range(0, SMAX));
               2: write_base(pfcf_pkg::CSR_PRESSURE_BASE,
                             ($urandom_range(0, 1) != 0) ? SMAX : 0);
               default: write_base(pfcf_pkg::CSR_FLOW_BASE,
                                   ($urandom_range(0, 1) != 0) ? SMAX : 0);
            endcase
         end
         ps = ($urandom_range(0, 1) != 0) ? $urandom_range(0, SMAX) : near_base(press_base);
         fs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SMAX) : near_base(flow_zero);
         send_sample(ps, fs);
      end
   endtask

   // receiver holds off long while the sender keeps offering
   task automatic test_backpressure;
      hold_off = 2500;
      for (int i = 0; i < 12; i++)
         send_sample($urandom_range(0, SMAX), near_base(flow_zero));
   endtask

   // sender waits for all outstanding results, then sends six samples
   task automatic test_pause;
      drain();
      for (int i = 0; i < 6; i++)
         send_sample($urandom_range(0, SMAX), $urandom_range(0, SMAX));
   endtask

   // receiver stall pattern, plus long hold-off on request
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(100, 1500);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         case (rx_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) != 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      filt_out_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filt_due.size() == 0) begin
            $display("%0t: unexpected response pressure %0d flow %0d",
                     $time, rsp_pressure_out, rsp_flow_out);
            errors++;
         end else begin
            due = filt_due.pop_front();
            if (rsp_pressure_out !== due.pressure) begin
               $display("%0t: pressure_out expected %0d actual %0d",
                        $time, due.pressure, rsp_pressure_out);
               errors++;
            end
            if (rsp_flow_out !== due.flow) begin
               $display("%0t: flow_out expected %0d actual %0d",
                        $time, due.flow, rsp_flow_out);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("pressure_flow_calibrate_filter verification failed");
         $finish;
      end
   end

   initial begin
      press_base = 1 << (SB - 1);
      flow_zero = 1 << (SB - 1);
      press_state = 0;
      flow_state = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(600);
      test_backpressure();
      test_random(400);
      test_pause();
      test_random(380);
      drain();
      repeat (400) @(posedge clock);
      if (errors == 0 && filt_due.size() == 0)
         $display("pressure_flow_calibrate_filter verification clean");
      else
         $display("pressure_flow_calibrate_filter verification failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
design/pfcf_pkg.sv
design/pfcf_serial.sv
design/pressure_flow_calibrate_filter.sv
bench/pressure_flow_calibrate_filter_test.sv
